FILE: sv/crle_pkg.sv
// Shared types and constants for the run-length scanline decoder.
package crle_pkg;

   localparam int BYTE_W  = 8;
   localparam int LEN_W   = 7;
   localparam int WIDTH_W = 15;

   localparam logic [WIDTH_W-1:0] WIDTH_RESET = WIDTH_W'(1);
   localparam logic [BYTE_W-1:0]  RUN_FLAG    = 8'h80;

   // Decoder phase: which kind of byte comes next.
   typedef enum logic [2:0] {
      PH_COUNT,
      PH_SKIP_A,
      PH_SKIP_B,
      PH_RUN,
      PH_LIT,
      PH_LIT_DROP
   } crle_phase_type;

   // Result of clipping a run against the room left in the line.
   typedef struct packed {
      logic [LEN_W-1:0]   count;
      logic               done;
      logic [WIDTH_W-1:0] pos_next;
   } crle_emit_type;

endpackage

FILE: sv/crle_clip.sv
// Clips a pixel run to the room left in the current scanline.
module crle_clip
   import crle_pkg::*;
(
   input  logic [WIDTH_W-1:0] line_width,
   input  logic [WIDTH_W-1:0] pixel_pos,
   input  logic [LEN_W-1:0]   run_len,
   output crle_emit_type      emit
);

   logic [WIDTH_W-1:0] room;
   logic [WIDTH_W-1:0] len_wide;
   logic [WIDTH_W-1:0] count_wide;

   // Room left, at least one pixel when the position is at or past the width
   assign room       = (line_width > pixel_pos) ? (line_width - pixel_pos) : WIDTH_W'(1);
   assign len_wide   = WIDTH_W'(run_len);
   assign count_wide = (len_wide < room) ? len_wide : room;

   // Count fits in the length field: it never exceeds the run length
   assign emit.count    = count_wide[LEN_W-1:0];
   assign emit.done     = (count_wide == room);
   assign emit.pos_next = emit.done ? '0 : (pixel_pos + count_wide);

endmodule

FILE: sv/cut_rle_scanline_decoder.sv
// Run-length scanline decoder: one coded byte in per cycle, pixel runs out.
//
// Takes one coded byte per clock cycle and gives at most one pixel run per
// byte, on the rsp side in the cycle after the byte is accepted; a run follows
// its value byte or literal byte directly. All decoding is a single pass
// through the phase logic and the line clipper between the decoder state and
// the result register, so a byte can be taken every cycle. The only stall
// toward the req side comes from a full result register that the rsp side is
// stalling. A zero count byte skips the next two bytes; a count byte with the
// top bit set repeats the next byte as a run of its low seven bits; any other
// count byte announces that many literal bytes. Runs are clipped to the line
// and literals past the line end are dropped. The user must write line_width
// through the csr port only while the decoder is idle; nothing enforces it.
module cut_rle_scanline_decoder
   import crle_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   // configuration
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [WIDTH_W-1:0] csr_line_width,
   // coded byte stream
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [BYTE_W-1:0]  req_byte_in,
   // pixel runs
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [BYTE_W-1:0]  rsp_pixel_value,
   output logic [LEN_W-1:0]   rsp_repeat_len,
   output logic               rsp_line_done
);

   crle_phase_type     phase_ff, phase_in;
   logic [LEN_W-1:0]   left_ff, left_in;
   logic [WIDTH_W-1:0] pos_ff, pos_in;
   logic [WIDTH_W-1:0] width_ff;
   logic               out_valid_ff, out_valid_in;
   logic [BYTE_W-1:0]  out_value_ff;
   logic [LEN_W-1:0]   out_len_ff;
   logic               out_done_ff;

   logic               accept;
   logic               produce;
   logic [LEN_W-1:0]   run_len;
   logic [LEN_W-1:0]   left_dec;
   crle_emit_type      emit;

   // Stall only while a finished run waits and the rsp side holds it
   assign req_stall = out_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   assign left_dec = left_ff - LEN_W'(1);

   // Literals clip a single pixel, runs their whole length
   assign run_len = (phase_ff == PH_RUN) ? left_ff : LEN_W'(1);

   crle_clip u_clip (
      .line_width (width_ff),
      .pixel_pos  (pos_ff),
      .run_len    (run_len),
      .emit       (emit)
   );

   // Next phase, packet count, position and whether a run comes out
   always_comb begin
      phase_in = phase_ff;
      left_in  = left_ff;
      pos_in   = pos_ff;
      produce  = 1'b0;
      case (phase_ff)
         PH_COUNT: begin
            if (req_byte_in == '0) begin
               phase_in = PH_SKIP_A;
               left_in  = '0;
            end else if ((req_byte_in & RUN_FLAG) != '0) begin
               phase_in = PH_RUN;
               left_in  = req_byte_in[LEN_W-1:0];
            end else begin
               phase_in = PH_LIT;
               left_in  = req_byte_in[LEN_W-1:0];
            end
         end
         PH_SKIP_A: begin
            phase_in = PH_SKIP_B;
         end
         PH_SKIP_B: begin
            phase_in = PH_COUNT;
         end
         PH_RUN: begin
            phase_in = PH_COUNT;
            if (left_ff != '0) begin
               produce = 1'b1;
               pos_in  = emit.pos_next;
               left_in = '0;
            end
         end
         PH_LIT: begin
            produce = 1'b1;
            pos_in  = emit.pos_next;
            left_in = left_dec;
            if (left_dec == '0) begin
               phase_in = PH_COUNT;
            end else if (emit.done) begin
               phase_in = PH_LIT_DROP;
            end else begin
               phase_in = PH_LIT;
            end
         end
         PH_LIT_DROP: begin
            left_in = left_dec;
            if (left_dec == '0) begin
               phase_in = PH_COUNT;
            end
         end
         default: begin
            phase_in = PH_COUNT;
            left_in  = '0;
         end
      endcase
   end

   // Hold the result until taken; load a new one when a byte produces it
   assign out_valid_in = (accept && produce) || (out_valid_ff && rsp_stall);

   // Advance decoder state on each accepted byte
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_COUNT;
         left_ff      <= '0;
         pos_ff       <= '0;
         width_ff     <= WIDTH_RESET;
         out_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            phase_ff <= phase_in;
            left_ff  <= left_in;
            pos_ff   <= pos_in;
         end
         if (csr_valid && csr_ready) begin
            width_ff <= csr_line_width;
         end
         out_valid_ff <= out_valid_in;
      end
   end

   // Result word payload
   always_ff @(posedge clock) begin
      if (accept && produce) begin
         out_value_ff <= req_byte_in;
         out_len_ff   <= emit.count;
         out_done_ff  <= emit.done;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_pixel_value = out_value_ff;
   assign rsp_repeat_len  = out_len_ff;
   assign rsp_line_done   = out_done_ff;

endmodule

FILE: sv/crle_checker.sv
// Port-level checks for the run-length scanline decoder, bound to the top.
module crle_checker
   import crle_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              req_stall,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input logic [BYTE_W-1:0] rsp_pixel_value,
   input logic [LEN_W-1:0]  rsp_repeat_len,
   input logic              rsp_line_done
);

   // No result word right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result word present after reset");

   // Input stalls only behind a held result word
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("input stalled without a held result word");

   // Every run covers at least one pixel
   a_len_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_repeat_len != '0))
      else $error("result word with zero repeat length");

   // A stalled result word holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_pixel_value)
         && $stable(rsp_repeat_len) && $stable(rsp_line_done)))
      else $error("stalled result word changed");

endmodule

bind cut_rle_scanline_decoder crle_checker u_crle_checker (
   .clock           (clock),
   .reset           (reset),
   .req_stall       (req_stall),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_pixel_value (rsp_pixel_value),
   .rsp_repeat_len  (rsp_repeat_len),
   .rsp_line_done   (rsp_line_done)
);
